// ===== sv/sag_pkg.sv =====
package sag_pkg;

    localparam int ANGLE_FRAC_BITS = 12;

    // pi and band constants in 2^-12 rad
    localparam logic signed [17:0] PI_U     = 18'sd12868;
    localparam logic signed [17:0] HALF_PI  = 18'sd6434;
    localparam logic signed [17:0] TWO_PI   = 18'sd25736;
    localparam logic [13:0] MID_37 = 14'd2645;
    localparam logic [13:0] MID_60 = 14'd4289;
    localparam logic [13:0] MID_75 = 14'd5362;
    localparam logic [13:0] MID_95 = 14'd6791;

    localparam logic [15:0] W_LOBE_10  = 16'd23468;
    localparam logic [15:0] W_LOBE_7P5 = 16'd31291;
    localparam logic [15:0] W_LOBE_5   = 16'd46937;

    localparam logic signed [18:0] OUT_OF_BEAM  = -19'sd256000;
    localparam logic signed [18:0] NO_BAND_GAIN = -19'sd6400;
    localparam logic [10:0] DB6 = 11'd1536;

    localparam logic [2:0] REG_V_MAX  = 3'd0;
    localparam logic [2:0] REG_V_INV  = 3'd1;
    localparam logic [2:0] REG_TILT   = 3'd2;
    localparam logic [2:0] REG_H_MAX  = 3'd3;
    localparam logic [2:0] REG_H_INV  = 3'd4;
    localparam logic [2:0] REG_AZ     = 3'd5;
    localparam logic [2:0] REG_PEAK   = 3'd6;
    localparam logic [2:0] REG_DUAL   = 3'd7;

    typedef struct packed {
        logic [13:0]        elev_angle;
        logic signed [15:0] azim_angle;
    } sag_in_t;

    typedef struct packed {
        logic signed [18:0] gain_out;
        logic               zero_point;
    } sag_out_t;

    // multiplier operand select
    typedef enum logic [1:0] {
        OP_V  = 2'd0,
        OP_H  = 2'd1,
        OP_L  = 2'd2
    } sag_op_t;

    typedef struct packed {
        logic    load;
        logic    mul_ratio;
        logic    mul_sq;
        sag_op_t op;
        logic    finish;
    } sag_cmd_t;

    typedef struct packed {
        logic out_of_beam;
        logic no_band;
    } sag_stat_t;

    // x wrapped into (-pi, pi]; a difference of two 16-bit angles spans under three turns
    function automatic logic signed [17:0] wrap(input logic signed [18:0] x);
        logic signed [18:0] y;
        y = x;
        if (y <= -PI_U) y = y + TWO_PI;
        if (y <= -PI_U) y = y + TWO_PI;
        if (y <= -PI_U) y = y + TWO_PI;
        if (y > PI_U) y = y - TWO_PI;
        if (y > PI_U) y = y - TWO_PI;
        if (y > PI_U) y = y - TWO_PI;
        return y[17:0];
    endfunction

    // strict band tests on theta; bounds are in 2^-12 rad, matching t*180*2^20 vs deg*pi_q32
    function automatic logic in_band(input logic [13:0] t, input logic [13:0] lo,
                                     input logic [13:0] hi);
        return (t > lo) && (t < hi);
    endfunction

endpackage

// ===== sv/sag_ctrl.sv =====
module sag_ctrl
    import sag_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  sag_stat_t stat,
    output sag_cmd_t  cmd
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_RV   = 8'b00000010,
        S_SV   = 8'b00000100,
        S_RH   = 8'b00001000,
        S_SH   = 8'b00010000,
        S_RL   = 8'b00100000,
        S_SL   = 8'b01000000,
        S_FIN  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = OP_V;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RV;
                end
            end
            S_RV:
            begin
                cmd.mul_ratio = 1'b1; cmd.op = OP_V; state_next = S_SV;
            end
            S_SV:
            begin
                cmd.mul_sq = 1'b1; cmd.op = OP_V; state_next = S_RH;
            end
            S_RH:
            begin
                cmd.mul_ratio = 1'b1; cmd.op = OP_H; state_next = S_SH;
            end
            S_SH:
            begin
                cmd.mul_sq = 1'b1; cmd.op = OP_H;
                state_next = (stat.out_of_beam || stat.no_band) ? S_FIN : S_RL;
            end
            S_RL:
            begin
                cmd.mul_ratio = 1'b1; cmd.op = OP_L; state_next = S_SL;
            end
            S_SL:
            begin
                cmd.mul_sq = 1'b1; cmd.op = OP_L; state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait here while the previous result is still held
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== sv/sag_dp.sv =====
module sag_dp
    import sag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  sag_in_t     req,
    input  sag_cmd_t    cmd,
    output sag_stat_t   stat,
    output sag_out_t    rsp
);
    logic [14:0]        v_max_reg, h_max_reg;
    logic [15:0]        v_inv_reg, h_inv_reg;
    logic signed [15:0] tilt_reg, az_reg;
    logic signed [14:0] peak_reg;
    logic               dual_reg;

    logic [15:0] lobe_w_reg;
    logic        lobe_half_reg, zero_reg;

    logic signed [17:0] th_reg, ph_reg, th2_reg;
    logic               band_half_reg, band_upd_reg, no_band_reg;
    logic [15:0]        band_w_reg;
    logic               oob_reg;
    logic [19:0]        r_reg;
    logic               sat_reg;
    logic [15:0]        av_reg, ah_reg;
    logic signed [16:0] a2_reg;
    logic signed [18:0] gain_reg;
    logic               zp_reg;

    // load: angles and band decode
    logic [13:0] t;
    logic        b1, b2, b3, b4;
    assign t  = req.elev_angle;
    assign b1 = in_band(t, 14'd2144, 14'd3217);
    assign b2 = in_band(t, 14'd3931, 14'd4647);
    assign b3 = in_band(t, 14'd5004, 14'd5720);
    assign b4 = in_band(t, 14'd6076, 14'd7507);

    // shared multipliers
    logic [16:0] ang_abs;
    logic [15:0] inv_sel;
    logic [32:0] prod_r;
    logic [39:0] prod_s;
    logic [14:0] cap_sel;
    logic        half_sel;
    logic [50:0] sq3;
    logic [50:0] sq_full;
    logic [18:0] sq_rnd;
    logic [15:0] sq_val;
    logic [16:0] lim;

    always_comb
    begin
        case (cmd.op)
            OP_H:    begin ang_abs = ph_reg[17] ? 17'(-ph_reg) : ph_reg[16:0];
                           inv_sel = h_inv_reg; end
            OP_L:    begin ang_abs = th2_reg[17] ? 17'(-th2_reg) : th2_reg[16:0];
                           inv_sel = lobe_w_reg; end
            default: begin ang_abs = th_reg[17] ? 17'(-th_reg) : th_reg[16:0];
                           inv_sel = v_inv_reg; end
        endcase
        prod_r   = 33'(ang_abs) * 33'(inv_sel);
        half_sel = (cmd.op == OP_L) && lobe_half_reg;
        cap_sel  = (cmd.op == OP_H) ? h_max_reg : v_max_reg;
        lim      = half_sel ? 17'(cap_sel) + 17'(DB6) : 17'(cap_sel);
        prod_s   = 40'(r_reg) * 40'(r_reg);
        // r^2 * 3072 (12 dB) or * 1536 (6 dB)
        sq3      = 51'(prod_s) + (51'(prod_s) << 1);
        sq_full  = half_sel ? (sq3 << 9) : (sq3 << 10);
        sq_rnd   = 19'((sq_full + (51'd1 << 31)) >> 32);
        if (sat_reg || (sq_rnd > 19'(lim)))
            sq_val = 16'(lim);
        else
            sq_val = 16'(sq_rnd);
    end

    assign stat.out_of_beam = oob_reg;
    assign stat.no_band     = no_band_reg;
    assign rsp.gain_out     = gain_reg;
    assign rsp.zero_point   = zp_reg;

    // the half-slope lobe can give a negative attenuation
    logic signed [17:0] av_min;
    logic signed [17:0] tot;
    assign av_min = (a2_reg < $signed({1'b0, av_reg})) ? 18'(a2_reg) :
                    $signed({2'b0, av_reg});
    assign tot    = (dual_reg ? av_min : $signed({2'b0, av_reg})) +
                    $signed({2'b0, ah_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_max_reg <= 15'd7680; v_inv_reg <= 16'd9387; tilt_reg <= 16'sd715;
            h_max_reg <= 15'd6400; h_inv_reg <= 16'd3911; az_reg <= '0;
            peak_reg <= '0; dual_reg <= 1'b1;
            lobe_w_reg <= W_LOBE_10; lobe_half_reg <= 1'b0; zero_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_V_MAX: v_max_reg <= cfg_data[14:0];
                    REG_V_INV: v_inv_reg <= cfg_data;
                    REG_TILT:  tilt_reg  <= cfg_data;
                    REG_H_MAX: h_max_reg <= cfg_data[14:0];
                    REG_H_INV: h_inv_reg <= cfg_data;
                    REG_AZ:    az_reg    <= cfg_data;
                    REG_PEAK:  peak_reg  <= cfg_data[14:0];
                    REG_DUAL:  dual_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.mul_sq && cmd.op == OP_H && !oob_reg && dual_reg)
            begin
                zero_reg <= no_band_reg;
                if (band_upd_reg)
                begin
                    lobe_w_reg    <= band_w_reg;
                    lobe_half_reg <= band_half_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            th_reg  <= wrap(19'($signed({1'b0, t})) - 19'(HALF_PI) - 19'(tilt_reg));
            ph_reg  <= wrap(19'(req.azim_angle) - 19'(az_reg));
            band_upd_reg  <= b1 || b2 || b3;
            band_half_reg <= 1'b1;
            band_w_reg    <= b1 ? W_LOBE_7P5 : W_LOBE_5;
            no_band_reg   <= !(b1 || b2 || b3 || b4);
            th2_reg <= wrap(19'($signed({1'b0, t})) -
                            19'($signed({1'b0, b1 ? MID_37 : b2 ? MID_60 :
                                                b3 ? MID_75 : MID_95})));
            oob_reg <= 1'b0;
        end
        if (cmd.mul_ratio)
        begin
            sat_reg <= prod_r >= (33'd8 << 24);
            r_reg   <= 20'((prod_r + 33'd128) >> 8);
            if (cmd.op == OP_H)
                oob_reg <= prod_r > (33'd1 << 24);
        end
        if (cmd.mul_sq)
        begin
            case (cmd.op)
                OP_V:    av_reg <= sq_val;
                OP_H:    begin
                             ah_reg <= sq_val;
                             if (!dual_reg) no_band_reg <= 1'b0;
                             a2_reg <= 17'sd32767;
                         end
                default: a2_reg <= lobe_half_reg ? 17'(sq_val) - 17'(DB6) : 17'(sq_val);
            endcase
        end
        if (cmd.finish)
        begin
            zp_reg <= zero_reg;
            if (oob_reg)
                gain_reg <= OUT_OF_BEAM;
            else if (no_band_reg)
                gain_reg <= NO_BAND_GAIN;
            else
                gain_reg <= 19'(peak_reg) -
                            19'((tot > $signed({3'b0, h_max_reg})) ?
                                $signed({3'b0, h_max_reg}) : tot);
        end
    end
endmodule

// ===== sv/sector_antenna_gain_top.sv =====
// Each accepted request steps the shared multipliers through the vertical, horizontal
// and lobe products, a ratio state and then a square state for each, and then the
// finish state; the lobe states are skipped when the direction is outside the
// horizontal beam or outside every dual-beam band. A new request is taken only in
// idle; a result held by out_ready stalls the next request in its final step.
// Reset (async, active low) loads register defaults, the 10 degree lobe
// and clears the zero-point flag.
module sector_antenna_gain_top
    import sag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  sag_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output sag_out_t    out_data
);
    sag_cmd_t  cmd;
    sag_stat_t stat;

    sag_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
        .stat, .cmd
    );

    sag_dp u_dp (
        .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_data,
        .req(in_data), .cmd, .stat, .rsp(out_data)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped or changed while stalled");
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.gain_out >= OUT_OF_BEAM))
        else $error("gain below range");
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mul_ratio && cmd.mul_sq)) else $error("multiplier conflict");
endmodule

// ===== test/tb_top.sv =====
module tb_top
    import sag_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PI_Q32 = 64'd13493037705;
    localparam int STALL_LIMIT = 3000;

    class gain_scoreboard;
        logic [14:0] v_max_atten;
        logic [15:0] v_inv_width;
        logic signed [15:0] down_tilt;
        logic [14:0] h_max_atten;
        logic [15:0] h_inv_width;
        logic signed [15:0] boresight_az;
        logic signed [14:0] peak_gain;
        logic dual_beam_on;
        logic [15:0] lobe_inv_width;
        logic lobe_half_slope;
        logic zero_flag_held;
        sag_out_t gain_q[$];
        int mismatches;

        function new();
            v_max_atten = 15'd7680;
            v_inv_width = 16'd9387;
            down_tilt = 16'sd715;
            h_max_atten = 15'd6400;
            h_inv_width = 16'd3911;
            boresight_az = 16'sd0;
            peak_gain = 15'sd0;
            dual_beam_on = 1'b1;
            lobe_inv_width = 16'd23468;
            lobe_half_slope = 1'b0;
            zero_flag_held = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_V_MAX: v_max_atten = val[14:0];
                REG_V_INV: v_inv_width = val;
                REG_TILT:  down_tilt = val;
                REG_H_MAX: h_max_atten = val[14:0];
                REG_H_INV: h_inv_width = val;
                REG_AZ:    boresight_az = val;
                REG_PEAK:  peak_gain = val[14:0];
                default:   dual_beam_on = val[0];
            endcase
        endfunction

        function longint pi_u();
            return (PI_Q32 + (64'd1 << 19)) >>> 20;
        endfunction

        function longint deg_to_angle(longint deg);
            return (deg * PI_Q32 / 180 + (64'd1 << 19)) >>> 20;
        endfunction

        // strict lo < theta < hi, bounds in degrees
        function bit theta_in_band(longint t, longint lo, longint hi);
            longint lhs;
            lhs = (t * 180) << 20;
            return lhs > lo * PI_Q32 && lhs < hi * PI_Q32;
        endfunction

        function longint wrap_pi(longint x);
            longint p;
            p = pi_u();
            while (x <= -p) x += 2 * p;
            while (x > p) x -= 2 * p;
            return x;
        endfunction

        function longint ratio_prod(longint ang, longint inv);
            return (ang < 0 ? -ang : ang) * inv;
        endfunction

        function longint parabolic_atten(longint ang, longint inv, longint coef,
                                         longint cap);
            longint p, r, v;
            p = ratio_prod(ang, inv);
            if (p >= (longint'(8) << 24))
                return cap;
            r = (p + 128) >>> 8;
            v = (r * r * coef + (longint'(1) << 31)) >>> 32;
            return v > cap ? cap : v;
        endfunction

        function void note_request(sag_in_t req);
            longint t, th, ph, av, ah, a2, tot, mid;
            sag_out_t res;
            t = req.elev_angle;
            th = wrap_pi(t - pi_u() / 2 - down_tilt);
            av = parabolic_atten(th, v_inv_width, 3072, v_max_atten);
            ph = wrap_pi(longint'(req.azim_angle) - boresight_az);
            if (ratio_prod(ph, h_inv_width) > (longint'(1) << 24)) begin
                res.gain_out = OUT_OF_BEAM;
                res.zero_point = zero_flag_held;
                gain_q.push_back(res);
                return;
            end
            ah = parabolic_atten(ph, h_inv_width, 3072, h_max_atten);
            if (dual_beam_on) begin
                if (theta_in_band(t, 30, 45)) begin
                    mid = 37; lobe_inv_width = W_LOBE_7P5; lobe_half_slope = 1'b1;
                end else if (theta_in_band(t, 55, 65)) begin
                    mid = 60; lobe_inv_width = W_LOBE_5; lobe_half_slope = 1'b1;
                end else if (theta_in_band(t, 70, 80)) begin
                    mid = 75; lobe_inv_width = W_LOBE_5; lobe_half_slope = 1'b1;
                end else if (theta_in_band(t, 85, 105)) begin
                    mid = 95;
                end else begin
                    zero_flag_held = 1'b1;
                    res.gain_out = NO_BAND_GAIN;
                    res.zero_point = 1'b1;
                    gain_q.push_back(res);
                    return;
                end
                zero_flag_held = 1'b0;
                th = wrap_pi(t - deg_to_angle(mid));
                if (lobe_half_slope)
                    a2 = parabolic_atten(th, lobe_inv_width, 1536,
                                         longint'(v_max_atten) + 1536) - 1536;
                else
                    a2 = parabolic_atten(th, lobe_inv_width, 3072, v_max_atten);
                if (a2 < av) av = a2;
            end
            tot = av + ah;
            if (tot > longint'(h_max_atten)) tot = longint'(h_max_atten);
            res.gain_out = 19'(longint'(peak_gain) - tot);
            res.zero_point = zero_flag_held;
            gain_q.push_back(res);
        endfunction

        function void check_result(sag_out_t got);
            sag_out_t exp_res;
            if (gain_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result gain=%0d zp=%0d",
                             got.gain_out, got.zero_point);
                return;
            end
            exp_res = gain_q.pop_front();
            if (got.gain_out !== exp_res.gain_out || got.zero_point !== exp_res.zero_point)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp gain=%0d zp=%0d got gain=%0d zp=%0d",
                             exp_res.gain_out, exp_res.zero_point,
                             got.gain_out, got.zero_point);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_addr;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    sag_in_t in_data;
    logic out_valid;
    logic out_ready;
    sag_out_t out_data;

    gain_scoreboard sb;
    int idle_mode;
    int stall_cnt;

    sector_antenna_gain_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver side: ready drops in the stalling modes
    always @(negedge clk)
    begin
        if (idle_mode == 2)
            out_ready <= ($urandom_range(99) >= 48);
        else if (idle_mode == 3)
            out_ready <= ($urandom_range(99) >= 24);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cnt <= 0;
        else if (rst_n)
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("sector_antenna_gain_top regression: fail");
            $finish;
        end
    end

    task automatic send_request(logic [13:0] elev, logic signed [15:0] azim);
        int gap;
        @(negedge clk);
        gap = 0;
        if (idle_mode == 1)
            gap = ($urandom_range(99) < 48);
        else if (idle_mode == 3)
            gap = ($urandom_range(99) < 24);
        while (gap != 0)
        begin
            in_valid = 1'b0;
            @(negedge clk);
            gap = (idle_mode == 1) ? ($urandom_range(99) < 48) :
                  (idle_mode == 3) ? ($urandom_range(99) < 24) : 0;
        end
        in_valid = 1'b1;
        in_data.elev_angle = elev;
        in_data.azim_angle = azim;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(in_data);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.gain_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_setting(int v_max, int v_inv, int tilt, int h_max, int h_inv,
                                int az, int peak, int dual);
        write_reg(REG_V_MAX, 16'(v_max));
        write_reg(REG_V_INV, 16'(v_inv));
        write_reg(REG_TILT, 16'(tilt));
        write_reg(REG_H_MAX, 16'(h_max));
        write_reg(REG_H_INV, 16'(h_inv));
        write_reg(REG_AZ, 16'(az));
        write_reg(REG_PEAK, 16'(peak));
        write_reg(REG_DUAL, 16'(dual));
    endtask

    // mostly aim inside the horizontal beam, otherwise anywhere
    task automatic random_requests(int n);
        int k, span, bounds[8], t, a, d;
        bounds = '{30, 45, 55, 65, 70, 80, 85, 105};
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(9) < 2)
            begin
                d = bounds[$urandom_range(7)];
                t = int'(sb.deg_to_angle(d)) + $urandom_range(2) - 1;
            end else
                t = $urandom_range(12868);
            if ($urandom_range(9) < 7)
            begin
                span = (sb.h_inv_width == 0) ? 25736 : (1 << 24) / sb.h_inv_width + 2;
                if (span > 25736) span = 25736;
                a = int'(sb.boresight_az) + int'($urandom_range(2 * span)) - span;
                if (a > 25736) a -= 25736;
                if (a < -25736) a += 25736;
            end else
                a = $urandom_range(51472) - 25736;
            send_request(14'(t), 16'(a));
            if (k == n / 2 && $urandom_range(1) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        sb = new();
        idle_mode = 0;
        stall_cnt = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 95 deg first: uses the lobe loaded at reset
        send_request(14'(sb.deg_to_angle(95)), 16'sd0);
        send_request(14'd0, 16'sd0);
        send_request(14'd12868, 16'sd0);
        send_request(14'd6434, 16'sd25736);
        send_request(14'd6434, -16'sd25736);
        send_request(14'(sb.deg_to_angle(30)), 16'sd100);
        send_request(14'(sb.deg_to_angle(30) + 1), 16'sd100);
        send_request(14'(sb.deg_to_angle(37)), -16'sd300);
        send_request(14'(sb.deg_to_angle(45) - 1), 16'sd0);
        send_request(14'(sb.deg_to_angle(60)), 16'sd0);
        send_request(14'(sb.deg_to_angle(75)), 16'sd4000);
        send_request(14'(sb.deg_to_angle(95)), 16'sd0);
        send_request(14'(sb.deg_to_angle(85) + 1), 16'sd0);
        send_request(14'(sb.deg_to_angle(105) - 1), 16'sd0);
        send_request(14'(sb.deg_to_angle(105) + 1), 16'sd0);
        send_request(14'(sb.deg_to_angle(50)), 16'sd5000);
        send_request(14'(sb.deg_to_angle(50)), 16'sd0);
        send_request(14'(sb.deg_to_angle(95)), 16'sd0);
        send_request(14'h3FFF & 14'd8191, 16'sd4290);
        send_request(14'd4096, 16'sd4291);
        wait_drained();

        idle_mode = 0;
        load_setting(25600, 65535, -25736, 25600, 65535, 25736, 12800, 1);
        random_requests(450);
        idle_mode = 1;
        load_setting(0, 1, 25736, 0, 1, -25736, -12800, 0);
        random_requests(300);
        idle_mode = 2;
        load_setting(12000, 0, -3000, 20000, 0, 5000, 3000, 1);
        random_requests(450);
        idle_mode = 3;
        load_setting(7680, 9387, 715, 6400, 2000, 0, 0, 1);
        random_requests(600);

        if (sb.mismatches == 0 && sb.gain_q.size() == 0)
            $display("sector_antenna_gain_top regression: pass");
        else
            $display("sector_antenna_gain_top regression: fail");
        $finish;
    end
endmodule
